@@ rtl/slss_pkg.sv @@
// shared types and constants for the stair light sweep sequencer
package slss_pkg;

  localparam int RELAY_COUNT = 15;
  localparam int ADDR_W = 4;

  localparam logic [ADDR_W-3:0] REG_STEP_DELAY = 2'd0;
  localparam logic [ADDR_W-3:0] REG_HOLD = 2'd1;
  localparam logic [ADDR_W-3:0] REG_DEBOUNCE = 2'd2;

  localparam logic [15:0] STEP_DELAY_RESET = 16'd500;
  localparam logic [15:0] HOLD_RESET = 16'd2000;
  localparam logic [9:0] DEBOUNCE_RESET = 10'd50;

  typedef struct packed {
    logic top_raw;
    logic bottom_raw;
  } sensor_t;

  typedef struct packed {
    logic [RELAY_COUNT-1:0] relay_mask;
    logic [2:0]             phase;
  } relay_t;

endpackage

@@ rtl/stair_light_sweep_sequencer_unit.sv @@
// stair light sweep sequencer: debounce, on/hold/off sweep control and register port
// path: an accepted sensor beat reaches its relay beat through the input
//   register, then the result register loaded with the new state
// throughput: one beat per cycle while relay_stall is low; the whole tick is one combinational pass
//   between the input register and the state and result registers
// reset: rst clears all sequencer state, empties both stages and loads the
//   register defaults; there is no clearing pass
module stair_light_sweep_sequencer_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sensor_valid,
  output logic                         sensor_stall,
  input  slss_pkg::sensor_t            sensor,
  output logic                         relay_valid,
  input  logic                         relay_stall,
  output slss_pkg::relay_t             relay,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slss_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int RC = slss_pkg::RELAY_COUNT;
  localparam logic signed [5:0] POS_FIRST = 6'sd0;
  localparam logic signed [5:0] POS_LAST = 6'(RC - 1);
  localparam logic signed [5:0] POS_END = 6'(RC);
  localparam logic signed [5:0] POS_NONE = -6'sd1;
  localparam logic signed [5:0] POS_MAX = 6'sd31;
  localparam logic signed [5:0] POS_MIN = -6'sd32;
  localparam int TOP = 0;
  localparam int BOT = 1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ON,
    PH_WAIT,
    PH_OFF,
    PH_OFF_ON
  } phase_t;

  // configuration registers
  logic [15:0] step_delay_ms;
  logic [15:0] hold_ms;
  logic [9:0]  debounce_ms;

  // input stage
  logic              in_q_valid;
  slss_pkg::sensor_t in_q;
  logic [1:0]        raw;

  // sequencer state
  logic [31:0]       now_ms;
  phase_t            seq_phase;
  logic [1:0]        prev_raw;
  logic [1:0]        stable_level;
  logic [31:0]       debounce_stamp [2];
  logic [1:0]        sweep_armed;
  logic signed [5:0] sweep_pos [2];
  logic [31:0]       sweep_step_stamp [2];
  logic [31:0]       trigger_stamp [2];
  logic              off_from_bottom;
  logic [31:0]       off_step_stamp;
  logic [31:0]       hold_start;
  logic [RC-1:0]     relay_bits;

  // next state
  phase_t            seq_phase_next;
  logic [1:0]        prev_raw_next;
  logic [1:0]        stable_level_next;
  logic [31:0]       debounce_stamp_next [2];
  logic [1:0]        sweep_armed_next;
  logic signed [5:0] sweep_pos_next [2];
  logic [31:0]       sweep_step_stamp_next [2];
  logic [31:0]       trigger_stamp_next [2];
  logic              off_from_bottom_next;
  logic [31:0]       off_step_stamp_next;
  logic [31:0]       hold_start_next;
  logic [RC-1:0]     relay_bits_next;

  logic advance;
  logic same_dir;
  logic opp_dir;

  // ---------------------------------------------------------------------------
  // helpers

  // wrapping elapsed-time test
  function automatic logic elapsed(input logic [31:0] now, input logic [31:0] stamp,
                                   input logic [31:0] limit);
    logic [31:0] diff;
    diff = now - stamp;
    return diff >= limit;
  endfunction

  // write one relay bit, ignoring step indexes outside the stair
  function automatic logic [RC-1:0] relay_write(input logic [RC-1:0] bits,
                                                input logic signed [5:0] idx,
                                                input logic on);
    logic [RC-1:0] r;
    r = bits;
    for (int i = 0; i < RC; i++) begin
      if (idx == 6'(i)) begin
        r[i] = on;
      end
    end
    return r;
  endfunction

  function automatic logic signed [5:0] sat_inc(input logic signed [5:0] p);
    return (p == POS_MAX) ? p : p + 6'sd1;
  endfunction

  function automatic logic signed [5:0] sat_dec(input logic signed [5:0] p);
    return (p == POS_MIN) ? p : p - 6'sd1;
  endfunction

  // ---------------------------------------------------------------------------
  // register port: writes land on the access cycle, reads are plain muxing

  assign pready = 1'b1;

  always_comb begin
    case (paddr[slss_pkg::ADDR_W-1:2])
      slss_pkg::REG_STEP_DELAY: prdata = {16'b0, step_delay_ms};
      slss_pkg::REG_HOLD:       prdata = {16'b0, hold_ms};
      slss_pkg::REG_DEBOUNCE:   prdata = {22'b0, debounce_ms};
      default:                  prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay_ms <= slss_pkg::STEP_DELAY_RESET;
      hold_ms       <= slss_pkg::HOLD_RESET;
      debounce_ms   <= slss_pkg::DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[slss_pkg::ADDR_W-1:2])
        slss_pkg::REG_STEP_DELAY: step_delay_ms <= pwdata[15:0];
        slss_pkg::REG_HOLD:       hold_ms       <= pwdata[15:0];
        slss_pkg::REG_DEBOUNCE:   debounce_ms   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: the tick in the input register moves on whenever the result
  // register is empty or being emptied; a waiting result stalls intake only
  // once the input register is full as well

  assign advance      = in_q_valid && (!relay_valid || !relay_stall);
  assign sensor_stall = in_q_valid && relay_valid && relay_stall;
  assign raw          = {in_q.bottom_raw, in_q.top_raw};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (sensor_valid && !sensor_stall) begin
      in_q_valid <= 1'b1;
      in_q       <= sensor;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // one millisecond tick, evaluated in the same order as the sequence is defined

  always_comb begin
    seq_phase_next        = seq_phase;
    prev_raw_next         = prev_raw;
    stable_level_next     = stable_level;
    debounce_stamp_next   = debounce_stamp;
    sweep_armed_next      = sweep_armed;
    sweep_pos_next        = sweep_pos;
    sweep_step_stamp_next = sweep_step_stamp;
    trigger_stamp_next    = trigger_stamp;
    off_from_bottom_next  = off_from_bottom;
    off_step_stamp_next   = off_step_stamp;
    hold_start_next       = hold_start;
    relay_bits_next       = relay_bits;
    same_dir              = 1'b0;
    opp_dir               = 1'b0;

    // debounce both ends; a stable rising edge stamps the trigger and arms the
    // sweep unless the lights are in the hold phase
    for (int s = 0; s < 2; s++) begin
      if (raw[s] != prev_raw[s]) begin
        debounce_stamp_next[s] = now_ms;
      end
      if (elapsed(now_ms, debounce_stamp_next[s], {22'b0, debounce_ms}) &&
          raw[s] != stable_level[s]) begin
        stable_level_next[s] = raw[s];
        if (raw[s]) begin
          trigger_stamp_next[s] = now_ms;
          if (seq_phase != PH_WAIT) begin
            sweep_armed_next[s] = 1'b1;
          end
        end
      end
      prev_raw_next[s] = raw[s];
    end

    // idle: start the on sweep from whichever end is armed
    if (seq_phase_next == PH_IDLE && (sweep_armed_next[TOP] || sweep_armed_next[BOT])) begin
      seq_phase_next = PH_ON;
      if (sweep_armed_next[TOP]) begin
        sweep_pos_next[TOP] = POS_FIRST;
      end
      if (sweep_armed_next[BOT]) begin
        sweep_pos_next[BOT] = POS_LAST;
      end
    end

    // hold: any high sensor restarts the hold time; both positions follow the
    // current off direction every tick
    if (seq_phase_next == PH_WAIT) begin
      sweep_armed_next = 2'b00;
      if (stable_level_next[TOP] || stable_level_next[BOT]) begin
        hold_start_next = now_ms;
      end
      if (elapsed(now_ms, hold_start_next, {16'b0, hold_ms})) begin
        seq_phase_next       = PH_OFF;
        off_from_bottom_next = !(trigger_stamp_next[TOP] < trigger_stamp_next[BOT]);
      end
      sweep_pos_next[BOT] = off_from_bottom_next ? POS_LAST : POS_FIRST;
      sweep_pos_next[TOP] = off_from_bottom_next ? POS_LAST : POS_FIRST;
    end

    // off sweep interrupted: a trigger from the far end restarts the on sweep,
    // one from the near end runs on and off together
    if (seq_phase_next == PH_OFF) begin
      same_dir = off_from_bottom_next ? sweep_armed_next[BOT] : sweep_armed_next[TOP];
      opp_dir  = off_from_bottom_next ? sweep_armed_next[TOP] : sweep_armed_next[BOT];
      if (opp_dir) begin
        seq_phase_next = PH_ON;
      end else if (same_dir) begin
        seq_phase_next = PH_OFF_ON;
      end
    end

    // on sweep: top walks down the stair, bottom walks up
    if (seq_phase_next == PH_ON) begin
      if (sweep_armed_next[TOP] &&
          elapsed(now_ms, sweep_step_stamp_next[TOP], {16'b0, step_delay_ms})) begin
        if (sweep_pos_next[TOP] < POS_END) begin
          relay_bits_next = relay_write(relay_bits_next, sweep_pos_next[TOP], 1'b1);
          sweep_step_stamp_next[TOP] = now_ms;
          sweep_pos_next[TOP] = sat_inc(sweep_pos_next[TOP]);
        end
        if (sweep_pos_next[TOP] == POS_END) begin
          seq_phase_next          = PH_WAIT;
          hold_start_next         = now_ms;
          trigger_stamp_next[TOP] = now_ms;
        end
      end
      if (sweep_armed_next[BOT] &&
          elapsed(now_ms, sweep_step_stamp_next[BOT], {16'b0, step_delay_ms})) begin
        if (sweep_pos_next[BOT] >= POS_FIRST) begin
          relay_bits_next = relay_write(relay_bits_next, sweep_pos_next[BOT], 1'b1);
          sweep_step_stamp_next[BOT] = now_ms;
          sweep_pos_next[BOT] = sat_dec(sweep_pos_next[BOT]);
        end
        if (sweep_pos_next[BOT] == POS_NONE) begin
          seq_phase_next          = PH_WAIT;
          hold_start_next         = now_ms;
          trigger_stamp_next[BOT] = now_ms;
        end
      end
    end

    // off sweep; the last relay off ends the cycle
    if (seq_phase_next == PH_OFF) begin
      if (!off_from_bottom_next) begin
        if (sweep_pos_next[BOT] < POS_END &&
            elapsed(now_ms, off_step_stamp_next, {16'b0, step_delay_ms})) begin
          relay_bits_next = relay_write(relay_bits_next, sweep_pos_next[BOT], 1'b0);
          off_step_stamp_next = now_ms;
          sweep_pos_next[BOT] = sat_inc(sweep_pos_next[BOT]);
        end
        if (sweep_pos_next[BOT] == POS_END) begin
          seq_phase_next     = PH_IDLE;
          sweep_armed_next   = 2'b00;
          sweep_pos_next[TOP] = POS_FIRST;
          sweep_pos_next[BOT] = POS_LAST;
          trigger_stamp_next[TOP] = 32'b0;
          trigger_stamp_next[BOT] = 32'b0;
          relay_bits_next    = '0;
        end
      end else begin
        if (sweep_pos_next[TOP] >= POS_FIRST &&
            elapsed(now_ms, off_step_stamp_next, {16'b0, step_delay_ms})) begin
          relay_bits_next = relay_write(relay_bits_next, sweep_pos_next[TOP], 1'b0);
          off_step_stamp_next = now_ms;
          sweep_pos_next[TOP] = sat_dec(sweep_pos_next[TOP]);
        end
        if (sweep_pos_next[TOP] == POS_NONE) begin
          seq_phase_next     = PH_IDLE;
          sweep_armed_next   = 2'b00;
          sweep_pos_next[TOP] = POS_FIRST;
          sweep_pos_next[BOT] = POS_LAST;
          trigger_stamp_next[TOP] = 32'b0;
          trigger_stamp_next[BOT] = 32'b0;
          relay_bits_next    = '0;
        end
      end
    end

    // off with on: the off sweep runs ahead and the new on sweep follows it
    if (seq_phase_next == PH_OFF_ON) begin
      if (!off_from_bottom_next) begin
        if (!sweep_armed_next[BOT] && sweep_pos_next[BOT] < POS_END) begin
          if (elapsed(now_ms, off_step_stamp_next, {16'b0, step_delay_ms})) begin
            relay_bits_next = relay_write(relay_bits_next, sweep_pos_next[BOT], 1'b0);
            off_step_stamp_next = now_ms;
            sweep_pos_next[BOT] = sat_inc(sweep_pos_next[BOT]);
          end
          if (elapsed(now_ms, sweep_step_stamp_next[TOP], {16'b0, step_delay_ms})) begin
            relay_bits_next = relay_write(relay_bits_next, sweep_pos_next[TOP], 1'b1);
            sweep_step_stamp_next[TOP] = now_ms;
            sweep_pos_next[TOP] = sat_inc(sweep_pos_next[TOP]);
          end
        end else begin
          seq_phase_next = PH_ON;
        end
      end else begin
        if (!sweep_armed_next[TOP] && sweep_pos_next[TOP] >= POS_FIRST) begin
          if (elapsed(now_ms, off_step_stamp_next, {16'b0, step_delay_ms})) begin
            relay_bits_next = relay_write(relay_bits_next, sweep_pos_next[TOP], 1'b0);
            off_step_stamp_next = now_ms;
            sweep_pos_next[TOP] = sat_dec(sweep_pos_next[TOP]);
          end
          if (elapsed(now_ms, sweep_step_stamp_next[BOT], {16'b0, step_delay_ms})) begin
            relay_bits_next = relay_write(relay_bits_next, sweep_pos_next[BOT], 1'b1);
            sweep_step_stamp_next[BOT] = now_ms;
            sweep_pos_next[BOT] = sat_dec(sweep_pos_next[BOT]);
          end
        end else begin
          seq_phase_next = PH_ON;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // state and result register: both load together when the tick moves on

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_valid         <= 1'b0;
      now_ms              <= 32'b0;
      seq_phase           <= PH_IDLE;
      prev_raw            <= 2'b00;
      stable_level        <= 2'b00;
      debounce_stamp[TOP] <= 32'b0;
      debounce_stamp[BOT] <= 32'b0;
      sweep_armed         <= 2'b00;
      sweep_pos[TOP]      <= POS_FIRST;
      sweep_pos[BOT]      <= POS_LAST;
      sweep_step_stamp[TOP] <= 32'b0;
      sweep_step_stamp[BOT] <= 32'b0;
      trigger_stamp[TOP]  <= 32'b0;
      trigger_stamp[BOT]  <= 32'b0;
      off_from_bottom     <= 1'b0;
      off_step_stamp      <= 32'b0;
      hold_start          <= 32'b0;
      relay_bits          <= '0;
    end else if (advance) begin
      relay_valid      <= 1'b1;
      relay.relay_mask <= relay_bits_next;
      relay.phase      <= seq_phase_next;
      now_ms           <= now_ms + 32'd1;
      seq_phase        <= seq_phase_next;
      prev_raw         <= prev_raw_next;
      stable_level     <= stable_level_next;
      debounce_stamp   <= debounce_stamp_next;
      sweep_armed      <= sweep_armed_next;
      sweep_pos        <= sweep_pos_next;
      sweep_step_stamp <= sweep_step_stamp_next;
      trigger_stamp    <= trigger_stamp_next;
      off_from_bottom  <= off_from_bottom_next;
      off_step_stamp   <= off_step_stamp_next;
      hold_start       <= hold_start_next;
      relay_bits       <= relay_bits_next;
    end else if (relay_valid && !relay_stall) begin
      relay_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // checks

  // idle is only reached from reset or through the end of a cycle, both of which clear every relay
  a_idle_dark: assert property (@(posedge clk) disable iff (rst)
    relay_valid && relay.phase == PH_IDLE |-> relay.relay_mask == '0)
    else $error("relays lit while idle");

  // every tick that moves on advances the millisecond counter by exactly one
  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    advance |=> now_ms == $past(now_ms) + 32'd1)
    else $error("millisecond counter out of step");

  // a tick that moves on always shows up as a result beat
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> relay_valid)
    else $error("tick processed without a result beat");

  // without a tick the sequencer state holds
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(now_ms) && $stable(relay_bits) && $stable(seq_phase))
    else $error("sequencer state moved without a tick");

endmodule

@@ tb/sv/stair_light_sweep_sequencer_unit_tb.sv @@
// self-checking testbench for the stair light sweep sequencer unit
module stair_light_sweep_sequencer_unit_tb;

  // sequencer phase codes as they appear on the relay beat
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ON     = 3'd1;
  localparam logic [2:0] PH_WAIT   = 3'd2;
  localparam logic [2:0] PH_OFF    = 3'd3;
  localparam logic [2:0] PH_OFF_ON = 3'd4;

  localparam int END_TOP    = 0;
  localparam int END_BOTTOM = 1;
  localparam int LAST_STEP  = slss_pkg::RELAY_COUNT - 1;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int CALM_BEATS      = 150;
  localparam int DEFAULT_ROWS    = 4;
  localparam int DIRECTED_ROWS   = 26;
  localparam int SETTINGS_COUNT  = 6;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          sensor_valid = 1'b0;
  logic                          sensor_stall;
  slss_pkg::sensor_t             sensor       = '0;
  logic                          relay_valid;
  logic                          relay_stall  = 1'b0;
  slss_pkg::relay_t              relay;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [slss_pkg::ADDR_W-1:0]   paddr        = '0;
  logic [31:0]                   pwdata       = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // a hand-typed result rides along with its sensor beat
  logic                beat_known   = 1'b0;
  slss_pkg::relay_t    beat_want    = '0;

  int                  errors             = 0;
  int                  sensor_beats_sent  = 0;
  int                  cycle_count        = 0;
  logic                calm               = 1'b0;
  logic                hold_off_req       = 1'b0;
  logic                hold_off_done      = 1'b0;

  // relay beats still owed by the block, oldest first
  slss_pkg::relay_t    pending_relays [$];

  // shadow of the register file
  logic [15:0]         step_cfg     = slss_pkg::STEP_DELAY_RESET;
  logic [15:0]         hold_cfg     = slss_pkg::HOLD_RESET;
  logic [9:0]          debounce_cfg = slss_pkg::DEBOUNCE_RESET;

  // own copy of the sequencer state, values after reset
  logic [31:0]            clock_ms    = '0;
  logic [2:0]             seq_ph      = PH_IDLE;
  logic                   raw_last    [2] = '{1'b0, 1'b0};
  logic                   level_ok    [2] = '{1'b0, 1'b0};
  logic [31:0]            bounce_mark [2] = '{32'd0, 32'd0};
  logic                   armed       [2] = '{1'b0, 1'b0};
  int                     pos         [2] = '{0, LAST_STEP};
  logic [31:0]            step_mark   [2] = '{32'd0, 32'd0};
  logic [31:0]            trig_mark   [2] = '{32'd0, 32'd0};
  logic                   off_up      = 1'b0;
  logic [31:0]            off_mark    = '0;
  logic [31:0]            hold_mark   = '0;
  logic [slss_pkg::RELAY_COUNT-1:0] lamps = '0;

  typedef struct packed {
    slss_pkg::sensor_t s;
    logic              known;
    slss_pkg::relay_t  want;
  } dir_row_t;

  typedef struct {
    int step_ms;
    int hold_ms;
    int debounce_ms;
    int beats;
  } setting_t;

  // opening rows run at the reset settings, where nothing can settle in time;
  // the rest run with a step delay of 1 and no hold or debounce so a sweep starts at once
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{2'b00, 1'b1, {15'h0000, PH_IDLE}},
    '{2'b11, 1'b1, {15'h0000, PH_IDLE}},
    '{2'b10, 1'b1, {15'h0000, PH_IDLE}},
    '{2'b01, 1'b1, {15'h0000, PH_IDLE}},
    '{2'b10, 1'b1, {15'h0001, PH_ON}},
    '{2'b10, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b01, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b11, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b01, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b10, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0},
    '{2'b11, 1'b0, 18'd0},
    '{2'b00, 1'b0, 18'd0}
  };

  // register settings for the random part, hold and debounce at both extremes, step from 1 to its maximum;
  // the long hold and the huge step park the sequencer until the next setting
  setting_t setting_plan [SETTINGS_COUNT] = '{
    '{1,     0,     0,    260},
    '{2,     5,     2,    260},
    '{1,     65535, 0,    60},
    '{65535, 7,     1023, 60},
    '{3,     12,    1,    260},
    '{1,     3,     4,    300}
  };

  stair_light_sweep_sequencer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .sensor_valid (sensor_valid),
    .sensor_stall (sensor_stall),
    .sensor       (sensor),
    .relay_valid  (relay_valid),
    .relay_stall  (relay_stall),
    .relay        (relay),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // step index saturates at the 6-bit signed range
  function automatic int clip_pos(input int v);
    if (v > 31) return 31;
    if (v < -32) return -32;
    return v;
  endfunction

  // relay writes off the end of the staircase are dropped
  function automatic void set_lamp(input int idx, input logic on);
    if (idx < 0 || idx >= slss_pkg::RELAY_COUNT) return;
    lamps[idx] = on;
  endfunction

  // end of cycle: back to idle with every lamp off, both ends disarmed and reloaded, triggers zeroed;
  // step stamps, debounce state and off direction survive
  function automatic void close_cycle();
    seq_ph = PH_IDLE;
    armed[END_TOP] = 1'b0;
    armed[END_BOTTOM] = 1'b0;
    pos[END_TOP] = 0;
    pos[END_BOTTOM] = LAST_STEP;
    trig_mark[END_TOP] = '0;
    trig_mark[END_BOTTOM] = '0;
    lamps = '0;
  endfunction

  // one millisecond tick of the sequencer, elapsed times as wrapping 32-bit differences
  task automatic advance_stair_tick(input slss_pkg::sensor_t s, output slss_pkg::relay_t r);
    logic [31:0] t;
    logic [31:0] step_w;
    logic [31:0] hold_w;
    logic [31:0] deb_w;
    logic        raw [2];
    logic        same_end;
    logic        opp_end;
    t = clock_ms;
    step_w = {16'd0, step_cfg};
    hold_w = {16'd0, hold_cfg};
    deb_w = {22'd0, debounce_cfg};
    raw[END_TOP] = s.top_raw;
    raw[END_BOTTOM] = s.bottom_raw;

    // debounce; a settled rising level stamps a trigger and arms outside the hold
    for (int e = 0; e < 2; e++) begin
      if (raw[e] != raw_last[e]) bounce_mark[e] = t;
      if (t - bounce_mark[e] >= deb_w && raw[e] != level_ok[e]) begin
        level_ok[e] = raw[e];
        if (raw[e]) begin
          trig_mark[e] = t;
          if (seq_ph != PH_WAIT) armed[e] = 1'b1;
        end
      end
      raw_last[e] = raw[e];
    end

    if (seq_ph == PH_IDLE && (armed[END_TOP] || armed[END_BOTTOM])) begin
      seq_ph = PH_ON;
      if (armed[END_TOP]) pos[END_TOP] = 0;
      if (armed[END_BOTTOM]) pos[END_BOTTOM] = LAST_STEP;
    end

    // hold: extended while any settled level is high, positions reloaded every tick
    if (seq_ph == PH_WAIT) begin
      armed[END_TOP] = 1'b0;
      armed[END_BOTTOM] = 1'b0;
      if (level_ok[END_TOP] || level_ok[END_BOTTOM]) hold_mark = t;
      if (t - hold_mark >= hold_w) begin
        seq_ph = PH_OFF;
        off_up = (trig_mark[END_TOP] < trig_mark[END_BOTTOM]) ? 1'b0 : 1'b1;
      end
      pos[END_BOTTOM] = off_up ? LAST_STEP : 0;
      pos[END_TOP] = off_up ? LAST_STEP : 0;
    end

    // a fresh trigger during the off sweep: opposite end restarts, same end overlaps
    if (seq_ph == PH_OFF) begin
      same_end = off_up ? armed[END_BOTTOM] : armed[END_TOP];
      opp_end = off_up ? armed[END_TOP] : armed[END_BOTTOM];
      if (opp_end) seq_ph = PH_ON;
      else if (same_end) seq_ph = PH_OFF_ON;
    end

    if (seq_ph == PH_ON) begin
      if (armed[END_TOP] && t - step_mark[END_TOP] >= step_w) begin
        if (pos[END_TOP] < slss_pkg::RELAY_COUNT) begin
          set_lamp(pos[END_TOP], 1'b1);
          step_mark[END_TOP] = t;
          pos[END_TOP] = clip_pos(pos[END_TOP] + 1);
        end
        if (pos[END_TOP] == slss_pkg::RELAY_COUNT) begin
          seq_ph = PH_WAIT;
          hold_mark = t;
          trig_mark[END_TOP] = t;
        end
      end
      if (armed[END_BOTTOM] && t - step_mark[END_BOTTOM] >= step_w) begin
        if (pos[END_BOTTOM] >= 0) begin
          set_lamp(pos[END_BOTTOM], 1'b1);
          step_mark[END_BOTTOM] = t;
          pos[END_BOTTOM] = clip_pos(pos[END_BOTTOM] - 1);
        end
        if (pos[END_BOTTOM] == -1) begin
          seq_ph = PH_WAIT;
          hold_mark = t;
          trig_mark[END_BOTTOM] = t;
        end
      end
    end

    if (seq_ph == PH_OFF) begin
      if (!off_up) begin
        if (pos[END_BOTTOM] < slss_pkg::RELAY_COUNT && t - off_mark >= step_w) begin
          set_lamp(pos[END_BOTTOM], 1'b0);
          off_mark = t;
          pos[END_BOTTOM] = clip_pos(pos[END_BOTTOM] + 1);
        end
        if (pos[END_BOTTOM] == slss_pkg::RELAY_COUNT) close_cycle();
      end else begin
        if (pos[END_TOP] >= 0 && t - off_mark >= step_w) begin
          set_lamp(pos[END_TOP], 1'b0);
          off_mark = t;
          pos[END_TOP] = clip_pos(pos[END_TOP] - 1);
        end
        if (pos[END_TOP] == -1) close_cycle();
      end
    end

    // overlap: the off sweep and a new on sweep from the same end run together
    if (seq_ph == PH_OFF_ON) begin
      if (!off_up) begin
        if (!armed[END_BOTTOM] && pos[END_BOTTOM] < slss_pkg::RELAY_COUNT) begin
          if (t - off_mark >= step_w) begin
            set_lamp(pos[END_BOTTOM], 1'b0);
            off_mark = t;
            pos[END_BOTTOM] = clip_pos(pos[END_BOTTOM] + 1);
          end
          if (t - step_mark[END_TOP] >= step_w) begin
            set_lamp(pos[END_TOP], 1'b1);
            step_mark[END_TOP] = t;
            pos[END_TOP] = clip_pos(pos[END_TOP] + 1);
          end
        end else begin
          seq_ph = PH_ON;
        end
      end else begin
        if (!armed[END_TOP] && pos[END_TOP] >= 0) begin
          if (t - off_mark >= step_w) begin
            set_lamp(pos[END_TOP], 1'b0);
            off_mark = t;
            pos[END_TOP] = clip_pos(pos[END_TOP] - 1);
          end
          if (t - step_mark[END_BOTTOM] >= step_w) begin
            set_lamp(pos[END_BOTTOM], 1'b1);
            step_mark[END_BOTTOM] = t;
            pos[END_BOTTOM] = clip_pos(pos[END_BOTTOM] - 1);
          end
        end else begin
          seq_ph = PH_ON;
        end
      end
    end

    clock_ms = t + 32'd1;
    r.relay_mask = lamps;
    r.phase = seq_ph;
  endtask

  // register read over the apb port, compared with the value it should hold
  task automatic read_check(input logic [slss_pkg::ADDR_W-3:0] idx, input logic [31:0] want);
    logic [31:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $error("register %0d: expected %h, got %h", idx, want, got);
      errors++;
    end
  endtask

  // setup then access; the shadow follows once the access beat has gone through
  task automatic write_reg(input logic [slss_pkg::ADDR_W-3:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      slss_pkg::REG_STEP_DELAY: step_cfg = value[15:0];
      slss_pkg::REG_HOLD:       hold_cfg = value[15:0];
      slss_pkg::REG_DEBOUNCE:   debounce_cfg = value[9:0];
      default: ;
    endcase
    read_check(idx, value);
  endtask

  // stop offering and wait for every owed relay beat; the block is then idle
  task automatic drain_relays();
    sensor_valid <= 1'b0;
    @(posedge clk);
    while (pending_relays.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input int step_ms, input int hold_ms, input int debounce_ms);
    drain_relays();
    write_reg(slss_pkg::REG_STEP_DELAY, 32'(step_ms));
    write_reg(slss_pkg::REG_HOLD, 32'(hold_ms));
    write_reg(slss_pkg::REG_DEBOUNCE, 32'(debounce_ms));
  endtask

  // offer one sensor beat, sometimes after a gap, and hold it until taken
  task automatic send_sensor(input slss_pkg::sensor_t s, input logic known,
                             input slss_pkg::relay_t want);
    if (!calm && $urandom_range(0, 9) == 0) begin
      sensor_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    sensor_valid <= 1'b1;
    sensor <= s;
    beat_known <= known;
    beat_want <= want;
    do @(posedge clk); while (sensor_stall);
    sensor_beats_sent++;
  endtask

  // someone on the stairs: a press from one or both ends with contact bounce,
  // plain noise now and then, followed by a quiet stretch of varying length
  task automatic walk_episode();
    int                kind;
    int                span;
    int                quiet;
    slss_pkg::sensor_t s;
    kind = $urandom_range(0, 9);
    span = $urandom_range(1, 10);
    if (kind != 9) begin
      for (int k = 0; k < span; k++) begin
        case (kind)
          0, 1, 2, 3: s = '{top_raw: 1'b1, bottom_raw: 1'b0};
          4, 5, 6:    s = '{top_raw: 1'b0, bottom_raw: 1'b1};
          7:          s = '{top_raw: 1'b1, bottom_raw: (k >= span / 2)};
          default:    {s.top_raw, s.bottom_raw} = 2'($urandom_range(0, 3));
        endcase
        if (k < 2 && $urandom_range(0, 3) == 0)
          {s.top_raw, s.bottom_raw} = 2'($urandom_range(0, 3));
        send_sensor(s, 1'b0, '0);
      end
    end
    quiet = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 25);
    for (int k = 0; k < quiet; k++) send_sensor('0, 1'b0, '0);
  endtask

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin : relay_sink
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        relay_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        relay_stall <= 1'b0;
        hold_off_done = 1'b1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        relay_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        relay_stall <= 1'b0;
      end
    end
  end

  // scoreboard: check the outgoing relay beat first, then predict the accepted sensor beat
  always @(posedge clk) begin : scoreboard
    slss_pkg::relay_t due;
    slss_pkg::relay_t predicted;
    if (!rst) begin
      if (relay_valid && !relay_stall) begin
        if (pending_relays.size() == 0) begin
          $error("relay beat with nothing owed: relay_mask %h phase %0d",
                 relay.relay_mask, relay.phase);
          errors++;
        end else begin
          due = pending_relays.pop_front();
          if (relay.relay_mask !== due.relay_mask) begin
            $error("relay_mask: expected %h, got %h", due.relay_mask, relay.relay_mask);
            errors++;
          end
          if (relay.phase !== due.phase) begin
            $error("phase: expected %0d, got %0d", due.phase, relay.phase);
            errors++;
          end
        end
      end
      if (sensor_valid && !sensor_stall) begin
        advance_stair_tick(sensor, predicted);
        pending_relays.push_back(beat_known ? beat_want : predicted);
      end
    end
  end

  initial begin : stimulus
    int stop_at;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register defaults straight out of reset
    read_check(slss_pkg::REG_STEP_DELAY, {16'd0, slss_pkg::STEP_DELAY_RESET});
    read_check(slss_pkg::REG_HOLD, {16'd0, slss_pkg::HOLD_RESET});
    read_check(slss_pkg::REG_DEBOUNCE, {22'd0, slss_pkg::DEBOUNCE_RESET});

    // directed rows; after the opening rows switch to a step delay of 1 with zero hold and debounce
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == DEFAULT_ROWS) load_settings(1, 0, 0);
      send_sensor(directed_rows[i].s, directed_rows[i].known, directed_rows[i].want);
    end

    // random walks under each setting; the long receiver hold-off lands in the second
    for (int p = 0; p < SETTINGS_COUNT; p++) begin
      load_settings(setting_plan[p].step_ms, setting_plan[p].hold_ms,
                    setting_plan[p].debounce_ms);
      if (p == 1) hold_off_req = 1'b1;
      stop_at = sensor_beats_sent + setting_plan[p].beats;
      while (sensor_beats_sent < stop_at) begin
        if (p == SETTINGS_COUNT - 1 && sensor_beats_sent >= stop_at - CALM_BEATS)
          calm = 1'b1;
        walk_episode();
      end
    end

    // drain, then keep watching the relay port to catch any stray beat
    drain_relays();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
